[design/depq_pkg.sv]
// shared constants and types for the double-ended priority queue
`default_nettype none

package depq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int HELD_W     = 11;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_POP_MAX = 2'd1,
    MODE_POP_MIN = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  typedef struct packed {
    logic                         ins;
    logic                         shift;
    logic signed [VALUE_BITS-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/double_ended_priority_queue.sv]
// top level: double-ended priority queue over two mirrored sorted chains
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | input     | in_valid_i/in_stall_o | mode_i, value_i
//  out     | output    | out_valid_o/out_stall_i | is_empty_o, max_value_o,
//          |           |                       | min_value_o, held_count_o,
//          |           |                       | insert_dropped_o
//
// one word per cycle while out_stall_i is low; chains update, then results register
// the ascending chain holds the minimum and the descending chain the maximum
// in their head cells, so every operation is one parallel step of all cells
// reset clears only the count and handshake state, cell contents are unused
// while the output is stalled one further word is taken, then input stalls
`default_nettype none

module double_ended_priority_queue (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire [1:0]                              mode_i,
  input  wire signed [depq_pkg::VALUE_BITS-1:0]  value_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic                                   is_empty_o,
  output logic signed [depq_pkg::VALUE_BITS-1:0] max_value_o,
  output logic signed [depq_pkg::VALUE_BITS-1:0] min_value_o,
  output logic [depq_pkg::HELD_W-1:0]            held_count_o,
  output logic                                   insert_dropped_o
);
  import depq_pkg::*;

  logic                         accept_in;
  logic                         capture;
  logic                         pending_q, pending_d;
  logic                         out_valid_q, out_valid_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic                         drop_q, drop_d;
  logic                         full;
  logic                         empty;
  mode_e                        mode;
  cell_ctrl_t                   asc_ctrl;
  cell_ctrl_t                   desc_ctrl;
  logic signed [VALUE_BITS-1:0] asc_head;
  logic signed [VALUE_BITS-1:0] desc_head;

  logic                         is_empty_q;
  logic signed [VALUE_BITS-1:0] max_q;
  logic signed [VALUE_BITS-1:0] min_q;
  logic [HELD_W-1:0]            held_q;
  logic                         dropped_q;

  assign mode  = mode_e'(mode_i);
  assign full  = count_q == CNT_W'(CAPACITY);
  assign empty = count_q == '0;

  assign capture    = pending_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pending_q && !capture;
  assign accept_in  = in_valid_i && !in_stall_o;

  always_comb begin
    asc_ctrl  = '{ins: 1'b0, shift: 1'b0, value: value_i};
    desc_ctrl = '{ins: 1'b0, shift: 1'b0, value: value_i};
    count_d   = count_q;
    drop_d    = 1'b0;
    if (accept_in) begin
      unique case (mode)
        MODE_INSERT: begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            asc_ctrl.ins  = 1'b1;
            desc_ctrl.ins = 1'b1;
            count_d       = count_q + CNT_W'(1);
          end
        end
        MODE_POP_MAX: begin
          if (!empty) begin
            desc_ctrl.shift = 1'b1;
            count_d         = count_q - CNT_W'(1);
          end
        end
        MODE_POP_MIN: begin
          if (!empty) begin
            asc_ctrl.shift = 1'b1;
            count_d        = count_q - CNT_W'(1);
          end
        end
        MODE_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (accept_in) begin
      pending_d = 1'b1;
    end else if (capture) begin
      pending_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (capture) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      drop_q <= drop_d;
    end
    if (capture) begin
      is_empty_q <= empty;
      max_q      <= empty ? '0 : desc_head;
      min_q      <= empty ? '0 : asc_head;
      held_q     <= HELD_W'(count_q);
      dropped_q  <= drop_q;
    end
  end

  depq_chain u_asc (
    .clk_i   (clk_i),
    .desc_i  (1'b0),
    .count_i (count_q),
    .ctrl_i  (asc_ctrl),
    .head_o  (asc_head)
  );

  depq_chain u_desc (
    .clk_i   (clk_i),
    .desc_i  (1'b1),
    .count_i (count_q),
    .ctrl_i  (desc_ctrl),
    .head_o  (desc_head)
  );

  assign out_valid_o      = out_valid_q;
  assign is_empty_o       = is_empty_q;
  assign max_value_o      = max_q;
  assign min_value_o      = min_q;
  assign held_count_o     = held_q;
  assign insert_dropped_o = dropped_q;

endmodule

`default_nettype wire

[design/depq_cell.sv]
// one cell of a sorted chain: holds a value, takes from either neighbour
`default_nettype none

module depq_cell (
  input  wire                                   clk_i,
  input  wire                                   desc_i,
  input  wire                                   occ_i,
  input  depq_pkg::cell_ctrl_t                  ctrl_i,
  input  wire signed [depq_pkg::VALUE_BITS-1:0] prev_val_i,
  input  wire                                   prev_gt_i,
  input  wire signed [depq_pkg::VALUE_BITS-1:0] next_val_i,
  output logic signed [depq_pkg::VALUE_BITS-1:0] val_o,
  output logic                                  gt_o
);
  import depq_pkg::*;

  logic signed [VALUE_BITS-1:0] val_q, val_d;
  logic                         cmp;

  // behind the new word in the chain's order, or empty
  assign cmp  = desc_i ? (val_q < ctrl_i.value) : (val_q > ctrl_i.value);
  assign gt_o = !occ_i || cmp;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && gt_o) begin
      val_d = prev_gt_i ? prev_val_i : ctrl_i.value;
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

[design/depq_chain.sv]
// row of cells kept sorted, head cell at index zero
`default_nettype none

module depq_chain (
  input  wire                                   clk_i,
  input  wire                                   desc_i,
  input  wire [depq_pkg::CNT_W-1:0]             count_i,
  input  depq_pkg::cell_ctrl_t                  ctrl_i,
  output logic signed [depq_pkg::VALUE_BITS-1:0] head_o
);
  import depq_pkg::*;

  logic signed [VALUE_BITS-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]          gts;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         occ;
    logic signed [VALUE_BITS-1:0] prev_val;
    logic                         prev_gt;
    logic signed [VALUE_BITS-1:0] next_val;

    assign occ = count_i > CNT_W'(i);

    if (i == 0) begin : g_first
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_val = vals[i-1];
      assign prev_gt  = gts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_val = vals[i];
    end else begin : g_inner
      assign next_val = vals[i+1];
    end

    depq_cell u_cell (
      .clk_i      (clk_i),
      .desc_i     (desc_i),
      .occ_i      (occ),
      .ctrl_i     (ctrl_i),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .val_o      (vals[i]),
      .gt_o       (gts[i])
    );
  end

  assign head_o = vals[0];

endmodule

`default_nettype wire

[design/depq_checker.sv]
// port-level checks for the double-ended priority queue, bound to the top level
`default_nettype none

module depq_checker (
  input wire                                   clk_i,
  input wire                                   rst_ni,
  input wire                                   out_valid_o,
  input wire                                   out_stall_i,
  input wire                                   is_empty_o,
  input wire signed [depq_pkg::VALUE_BITS-1:0] max_value_o,
  input wire signed [depq_pkg::VALUE_BITS-1:0] min_value_o,
  input wire [depq_pkg::HELD_W-1:0]            held_count_o,
  input wire                                   insert_dropped_o
);
  import depq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(max_value_o)
      && $stable(min_value_o) && $stable(held_count_o))
    else $error("result word changed while stalled");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (held_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> max_value_o == '0 && min_value_o == '0)
    else $error("extremes not zero on empty store");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_empty_o |-> max_value_o >= min_value_o)
    else $error("maximum below minimum");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && insert_dropped_o |-> held_count_o == HELD_W'(CAPACITY))
    else $error("insert dropped while store not full");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .is_empty_o       (is_empty_o),
  .max_value_o      (max_value_o),
  .min_value_o      (min_value_o),
  .held_count_o     (held_count_o),
  .insert_dropped_o (insert_dropped_o)
);

`default_nettype wire
